// ===== sv/mgsh_pkg.sv =====
// mgsh_pkg: shared widths, register indexes and constant tables of the
// magnetometer heading pipeline; used by every module of the block
package mgsh_pkg;

    localparam int SCALE_FRACTION_BITS = 12;
    localparam int CORDIC_ITERATIONS   = 16;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int COUNT_W    = RAW_W + 1;
    localparam int FIELD_W    = 24;
    localparam int HEADING_W  = 16;
    localparam int GAIN_W     = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_CODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_OFFSET  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_OFFSET  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd1;

    // factor is at most 4.35 * 2^frac rounded to the nearest integer, so three integer bits suffice
    localparam int FACTOR_W    = SCALE_FRACTION_BITS + 3;
    localparam int PRODUCT_W   = COUNT_W + FACTOR_W + 1;
    localparam int ROUND_SHIFT = SCALE_FRACTION_BITS - 4;

    localparam int FIELD_MAX = 8388607;

    // cordic datapath: count scaled by 2^24 plus headroom for gain and sign
    localparam int CORDIC_INPUT_SHIFT = 24;
    localparam int CORDIC_W           = COUNT_W + CORDIC_INPUT_SHIFT + 3;
    localparam int ANGLE_W            = 33;
    localparam int ANGLE_TABLE_SIZE   = 24;
    localparam int ANGLE_FRAC_BITS    = 16;

    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_TURN = 33'sd1179648000;
    localparam int HEADING_MAX = 18000;

    // total pipeline: input stage, cordic load stage, cordic iterations, output register
    // (the two lane stages run beside the cordic)
    localparam int PIPE_DEPTH = CORDIC_ITERATIONS + 3;

    localparam int MG_THOUSANDTHS [8] = '{730, 920, 1220, 1520, 2270, 2560, 3030, 4350};

    function automatic logic [FACTOR_W-1:0] scale_factor(input int mg);
        longint t;
        t = (longint'(mg) << SCALE_FRACTION_BITS) + 64'sd500;
        return FACTOR_W'(t / 1000);
    endfunction

    localparam logic [FACTOR_W-1:0] FACTOR_TABLE [8] = '{
        scale_factor(MG_THOUSANDTHS[0]), scale_factor(MG_THOUSANDTHS[1]),
        scale_factor(MG_THOUSANDTHS[2]), scale_factor(MG_THOUSANDTHS[3]),
        scale_factor(MG_THOUSANDTHS[4]), scale_factor(MG_THOUSANDTHS[5]),
        scale_factor(MG_THOUSANDTHS[6]), scale_factor(MG_THOUSANDTHS[7])
    };

    // atan(2^-i) in 0.01 degree / 65536
    localparam logic [31:0] ATAN_TABLE [ANGLE_TABLE_SIZE] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
        32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
        32'd1466764,   32'd733385,    32'd366693,   32'd183346,
        32'd91673,     32'd45837,     32'd22918,    32'd11459,
        32'd5730,      32'd2865,      32'd1432,     32'd716,
        32'd358,       32'd179,       32'd90,       32'd45
    };

endpackage

// ===== sv/mgsh_scale_lane.sv =====
// mgsh_scale_lane: one axis lane, count times gain factor, then rounding
// to Q4 milligauss with saturation; depends on mgsh_pkg
module mgsh_scale_lane (
    input  logic                                 aclk,
    input  logic                                 adv,
    input  logic signed [mgsh_pkg::COUNT_W-1:0]  count,
    input  logic        [mgsh_pkg::FACTOR_W-1:0] factor,
    output logic signed [mgsh_pkg::FIELD_W-1:0]  field
);

    localparam int PW = mgsh_pkg::PRODUCT_W;

    logic signed [PW-1:0]                    product_reg;
    logic signed [mgsh_pkg::FIELD_W-1:0]     field_reg;
    logic signed [mgsh_pkg::FACTOR_W:0]      factor_s;
    logic        [PW-1:0]                    mag;
    logic        [PW-1:0]                    rounded;
    logic signed [mgsh_pkg::FIELD_W-1:0]     field_next;

    assign factor_s = {1'b0, factor};

    // magnitude rounding gives ties away from zero
    always_comb begin
        mag     = product_reg[PW-1] ? PW'(-product_reg) : PW'(product_reg);
        rounded = (mag + (PW'(1) << (mgsh_pkg::ROUND_SHIFT - 1))) >> mgsh_pkg::ROUND_SHIFT;
        if (!product_reg[PW-1]) begin
            if (rounded > PW'(mgsh_pkg::FIELD_MAX)) begin
                field_next = mgsh_pkg::FIELD_W'(mgsh_pkg::FIELD_MAX);
            end else begin
                field_next = rounded[mgsh_pkg::FIELD_W-1:0];
            end
        end else begin
            if (rounded > PW'(mgsh_pkg::FIELD_MAX + 1)) begin
                field_next = {1'b1, {(mgsh_pkg::FIELD_W-1){1'b0}}};
            end else begin
                field_next = -rounded[mgsh_pkg::FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            product_reg <= PW'(count * factor_s);
            field_reg   <= field_next;
        end
    end

    assign field = field_reg;

endmodule

// ===== sv/mgsh_cordic.sv =====
// mgsh_cordic: pipelined vectoring cordic, one iteration per stage, giving
// the angle of (dx, dy) in 0.01 degree / 65536; depends on mgsh_pkg
module mgsh_cordic (
    input  logic                                 aclk,
    input  logic                                 adv,
    input  logic signed [mgsh_pkg::COUNT_W-1:0]  dx,
    input  logic signed [mgsh_pkg::COUNT_W-1:0]  dy,
    output logic signed [mgsh_pkg::ANGLE_W-1:0]  angle,
    output logic                                 zero_vec
);

    localparam int N  = mgsh_pkg::CORDIC_ITERATIONS;
    localparam int W  = mgsh_pkg::CORDIC_W;
    localparam int AW = mgsh_pkg::ANGLE_W;

    logic signed [W-1:0]  x_reg    [0:N];
    logic signed [W-1:0]  y_reg    [0:N];
    logic signed [AW-1:0] z_reg    [0:N];
    logic                 zero_reg [0:N];

    logic signed [mgsh_pkg::COUNT_W-1:0] ix;
    logic signed [mgsh_pkg::COUNT_W-1:0] iy;
    logic signed [AW-1:0]                iz;

    // left half plane: negate and start from a half turn
    always_comb begin
        if (dx[mgsh_pkg::COUNT_W-1]) begin
            ix = -dx;
            iy = -dy;
            iz = dy[mgsh_pkg::COUNT_W-1] ? -mgsh_pkg::ANGLE_HALF_TURN
                                         : mgsh_pkg::ANGLE_HALF_TURN;
        end else begin
            ix = dx;
            iy = dy;
            iz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]    <= {{(W-mgsh_pkg::COUNT_W){ix[mgsh_pkg::COUNT_W-1]}}, ix}
                           <<< mgsh_pkg::CORDIC_INPUT_SHIFT;
            y_reg[0]    <= {{(W-mgsh_pkg::COUNT_W){iy[mgsh_pkg::COUNT_W-1]}}, iy}
                           <<< mgsh_pkg::CORDIC_INPUT_SHIFT;
            z_reg[0]    <= iz;
            zero_reg[0] <= (dx == '0) && (dy == '0);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [W-1:0]  xs;
        logic signed [W-1:0]  ys;
        logic signed [AW-1:0] step;

        assign xs   = x_reg[i] >>> i;
        assign ys   = y_reg[i] >>> i;
        assign step = {1'b0, mgsh_pkg::ATAN_TABLE[i]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + step;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - step;
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign angle    = z_reg[N];
    assign zero_vec = zero_reg[N];

endmodule

// ===== sv/mgsh_merge.sv =====
// mgsh_merge: lines the lane results up with the cordic angle, rounds the
// angle to hundredths of a degree and holds the output register; uses mgsh_pkg
module mgsh_merge (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  logic signed [mgsh_pkg::FIELD_W-1:0]   x_in,
    input  logic signed [mgsh_pkg::FIELD_W-1:0]   y_in,
    input  logic signed [mgsh_pkg::FIELD_W-1:0]   z_in,
    input  logic signed [mgsh_pkg::ANGLE_W-1:0]   angle,
    input  logic                                  zero_vec,
    output logic signed [mgsh_pkg::FIELD_W-1:0]   x_field,
    output logic signed [mgsh_pkg::FIELD_W-1:0]   y_field,
    output logic signed [mgsh_pkg::FIELD_W-1:0]   z_field,
    output logic signed [mgsh_pkg::HEADING_W-1:0] heading
);

    localparam int TAPS = mgsh_pkg::CORDIC_ITERATIONS - 1;
    localparam int AW   = mgsh_pkg::ANGLE_W;
    localparam int FW   = mgsh_pkg::FIELD_W;
    localparam int HW   = mgsh_pkg::HEADING_W;

    logic signed [FW-1:0] xd_reg [0:TAPS-1];
    logic signed [FW-1:0] yd_reg [0:TAPS-1];
    logic signed [FW-1:0] zd_reg [0:TAPS-1];

    logic signed [FW-1:0] x_out_reg;
    logic signed [FW-1:0] y_out_reg;
    logic signed [FW-1:0] z_out_reg;
    logic signed [HW-1:0] heading_reg;

    logic        [AW-1:0] angle_mag;
    logic        [AW-1:0] angle_sum;
    logic        [HW-1:0] heading_mag;
    logic signed [HW-1:0] heading_next;

    always_comb begin
        angle_mag = angle[AW-1] ? AW'(-angle) : AW'(angle);
        angle_sum = (angle_mag + (AW'(1) << (mgsh_pkg::ANGLE_FRAC_BITS - 1)))
                    >> mgsh_pkg::ANGLE_FRAC_BITS;
        if (angle_sum > AW'(mgsh_pkg::HEADING_MAX)) begin
            heading_mag = HW'(mgsh_pkg::HEADING_MAX);
        end else begin
            heading_mag = angle_sum[HW-1:0];
        end
        if (zero_vec) begin
            heading_next = '0;
        end else if (angle[AW-1]) begin
            heading_next = -heading_mag;
        end else begin
            heading_next = heading_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xd_reg[0] <= x_in;
            yd_reg[0] <= y_in;
            zd_reg[0] <= z_in;
            for (int k = 1; k < TAPS; k++) begin
                xd_reg[k] <= xd_reg[k-1];
                yd_reg[k] <= yd_reg[k-1];
                zd_reg[k] <= zd_reg[k-1];
            end
            x_out_reg   <= xd_reg[TAPS-1];
            y_out_reg   <= yd_reg[TAPS-1];
            z_out_reg   <= zd_reg[TAPS-1];
            heading_reg <= heading_next;
        end
    end

    assign x_field = x_out_reg;
    assign y_field = y_out_reg;
    assign z_field = z_out_reg;
    assign heading = heading_reg;

endmodule

// ===== sv/magnetometer_sample_heading.sv =====
// magnetometer_sample_heading: from input transfer to result valid a reading
// passes the input stage, cordic load stage, 16 cordic stages, output register.
// throughput one reading per cycle; the whole pipeline advances together and
// holds while a result waits, so the cordic stage count sets the latency.
// synchronous active-low reset clears valid bits and loads gain code 1 and
// zero offsets; no clearing pass.
module magnetometer_sample_heading (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic        [mgsh_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic        [mgsh_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_x_high_byte,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_x_low_byte,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_y_high_byte,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_y_low_byte,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_z_high_byte,
    input  logic        [mgsh_pkg::BYTE_W-1:0]     s_z_low_byte,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mgsh_pkg::FIELD_W-1:0]    m_x_field,
    output logic signed [mgsh_pkg::FIELD_W-1:0]    m_y_field,
    output logic signed [mgsh_pkg::FIELD_W-1:0]    m_z_field,
    output logic signed [mgsh_pkg::HEADING_W-1:0]  m_heading
);

    localparam int CW = mgsh_pkg::COUNT_W;
    localparam int D  = mgsh_pkg::PIPE_DEPTH;

    logic        [mgsh_pkg::GAIN_W-1:0]   gain_code_reg;
    logic signed [mgsh_pkg::RAW_W-1:0]    x_offset_reg;
    logic signed [mgsh_pkg::RAW_W-1:0]    y_offset_reg;

    logic        [D-1:0]                  valid_reg;
    logic signed [CW-1:0]                 dx_reg;
    logic signed [CW-1:0]                 dy_reg;
    logic signed [CW-1:0]                 rz_reg;
    logic        [mgsh_pkg::FACTOR_W-1:0] factor_reg;

    logic signed [mgsh_pkg::RAW_W-1:0]    raw_x;
    logic signed [mgsh_pkg::RAW_W-1:0]    raw_y;
    logic signed [mgsh_pkg::RAW_W-1:0]    raw_z;

    logic signed [mgsh_pkg::FIELD_W-1:0]  lane_x;
    logic signed [mgsh_pkg::FIELD_W-1:0]  lane_y;
    logic signed [mgsh_pkg::FIELD_W-1:0]  lane_z;
    logic signed [mgsh_pkg::ANGLE_W-1:0]  angle;
    logic                                 zero_vec;
    logic                                 adv;

    // pipeline moves whenever the output register is free or being drained
    assign adv     = !valid_reg[D-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = valid_reg[D-1];

    assign raw_x = {s_x_high_byte, s_x_low_byte};
    assign raw_y = {s_y_high_byte, s_y_low_byte};
    assign raw_z = {s_z_high_byte, s_z_low_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_code_reg <= mgsh_pkg::GAIN_RESET;
            x_offset_reg  <= '0;
            y_offset_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mgsh_pkg::REG_GAIN_CODE: gain_code_reg <= cfg_wdata[mgsh_pkg::GAIN_W-1:0];
                mgsh_pkg::REG_X_OFFSET:  x_offset_reg  <= cfg_wdata;
                mgsh_pkg::REG_Y_OFFSET:  y_offset_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[D-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg     <= CW'(raw_x) - CW'(x_offset_reg);
            dy_reg     <= CW'(raw_y) - CW'(y_offset_reg);
            rz_reg     <= CW'(raw_z);
            factor_reg <= mgsh_pkg::FACTOR_TABLE[gain_code_reg];
        end
    end

    mgsh_scale_lane u_lane_x (
        .aclk   (aclk),
        .adv    (adv),
        .count  (dx_reg),
        .factor (factor_reg),
        .field  (lane_x)
    );

    mgsh_scale_lane u_lane_y (
        .aclk   (aclk),
        .adv    (adv),
        .count  (dy_reg),
        .factor (factor_reg),
        .field  (lane_y)
    );

    mgsh_scale_lane u_lane_z (
        .aclk   (aclk),
        .adv    (adv),
        .count  (rz_reg),
        .factor (factor_reg),
        .field  (lane_z)
    );

    mgsh_cordic u_cordic (
        .aclk     (aclk),
        .adv      (adv),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .angle    (angle),
        .zero_vec (zero_vec)
    );

    mgsh_merge u_merge (
        .aclk     (aclk),
        .adv      (adv),
        .x_in     (lane_x),
        .y_in     (lane_y),
        .z_in     (lane_z),
        .angle    (angle),
        .zero_vec (zero_vec),
        .x_field  (m_x_field),
        .y_field  (m_y_field),
        .z_field  (m_z_field),
        .heading  (m_heading)
    );

endmodule

// ===== sv/mgsh_checker.sv =====
// mgsh_checker: port-level checks of the heading block, attached to the top
// level by the bind below; depends on mgsh_pkg
module mgsh_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [mgsh_pkg::FIELD_W-1:0]    m_x_field,
    input logic signed [mgsh_pkg::FIELD_W-1:0]    m_y_field,
    input logic signed [mgsh_pkg::FIELD_W-1:0]    m_z_field,
    input logic signed [mgsh_pkg::HEADING_W-1:0]  m_heading
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_field) && $stable(m_y_field)
                                && $stable(m_z_field) && $stable(m_heading))
        else $error("result changed while stalled");

    // input side only stalls while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading >= -16'sd18000) && (m_heading <= 16'sd18000))
        else $error("heading out of range");

    // largest corrected count 65535 at the highest gain factor
    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_x_field >= -24'sd4561338) && (m_x_field <= 24'sd4561338)
                 && (m_z_field >= -24'sd4561338) && (m_z_field <= 24'sd4561338))
        else $error("field out of range");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind magnetometer_sample_heading mgsh_checker u_checker (.*);
